// ===== sv/dhd_pkg.sv =====
// ----------------------------------------------------------------------------
// dhd_pkg - shared definitions for the double hash dictionary
// Table geometry, derived widths, status codes, entry and hash result types,
// and the residue step used by the key hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dhd_pkg;

	// Power of five, evaluated at elaboration
	function automatic int pow5(input int n);
		int acc;
		acc = 1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 5;
		end
		return acc;
	endfunction

	localparam int TABLE_SIZE  = 1021;
	localparam int MAX_SYMBOLS = 12;

	// Fixed field widths
	localparam int LEN_W    = 4;
	localparam int SYMS_W   = 24;
	localparam int STATUS_W = 2;
	localparam int SLOT_O_W = 10;

	// Derived widths
	localparam int SLOT_W    = $clog2(TABLE_SIZE);
	localparam int RED_W     = SLOT_W + 3;
	localparam int PROBE_W   = $clog2(TABLE_SIZE + 1);
	localparam int KEY_W     = $clog2(pow5(MAX_SYMBOLS));
	localparam int CNT_W     = $clog2(MAX_SYMBOLS + 1);
	localparam int SYM_REG_W = 2 * MAX_SYMBOLS;
	localparam int SYM_IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

	// Moduli
	localparam logic [SLOT_W-1:0] MOD_POS  = SLOT_W'(TABLE_SIZE);
	localparam logic [SLOT_W-1:0] MOD_STEP = SLOT_W'(TABLE_SIZE - 1);

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic              done;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] pos;
		logic [SLOT_W-1:0] step;
	} hash_res_t;

	// Residue update: (5*r + c) mod m for r < m, c in 1..4
	function automatic logic [SLOT_W-1:0] red5(
		input logic [SLOT_W-1:0] r,
		input logic [2:0]        c,
		input logic [SLOT_W-1:0] m
	);
		logic [RED_W-1:0] t;
		logic [RED_W-1:0] res;
		logic [RED_W-1:0] mk;
		t   = {3'b000, r} + {1'b0, r, 2'b00} + RED_W'(c);
		res = t;
		for (int k = 1; k < 6; k++) begin
			mk = RED_W'(k) * {3'b000, m};
			if (t >= mk) begin
				res = t - mk;
			end
		end
		return res[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/double_hash_dictionary_core.sv =====
// ----------------------------------------------------------------------------
// double_hash_dictionary_core - open-addressed nucleotide key dictionary
// Insert and find of short nucleotide strings in a double hashed table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, key_length and
//   key_symbols; a transfer happens when in_valid is high and in_stall low.
//   Output channel (out_valid/out_stall) carries status and slot_index, one
//   result per input item.
//   One item is worked on at a time. From the input transfer the key hash
//   unit folds n symbols (n = key length, saturated to MAX_SYMBOLS), then
//   each probe does a memory read, then a compare, then the finish step
//   loads the output register; at most TABLE_SIZE probes are made.
//   in_stall drops as soon as the result sits in the output register, so a
//   new item may transfer while that result waits on out_stall; a second
//   result waits in the finish step until the output register frees.
//   After reset a clearing pass writes every table slot empty, one slot a
//   cycle, with in_stall held high.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_dictionary_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          opcode,
	input  wire logic [dhd_pkg::LEN_W-1:0]     key_length,
	input  wire logic [dhd_pkg::SYMS_W-1:0]    key_symbols,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [dhd_pkg::STATUS_W-1:0]       status,
	output logic [dhd_pkg::SLOT_O_W-1:0]       slot_index
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	state_t                           state_q;
	logic [dhd_pkg::SLOT_W-1:0]       clr_q;
	logic                             op_q;
	logic [dhd_pkg::KEY_W-1:0]        key_q;
	logic [dhd_pkg::SLOT_W-1:0]       pos_q;
	logic [dhd_pkg::SLOT_W-1:0]       step_q;
	logic [dhd_pkg::PROBE_W-1:0]      probe_count_q;
	logic [dhd_pkg::STATUS_W-1:0]     stat_q;
	logic [dhd_pkg::SLOT_W-1:0]       slot_q;
	logic                             out_valid_q;
	logic [dhd_pkg::STATUS_W-1:0]     out_status_q;
	logic [dhd_pkg::SLOT_W-1:0]       out_slot_q;

	dhd_pkg::entry_t                  mem [dhd_pkg::TABLE_SIZE];
	dhd_pkg::entry_t                  rd_q;
	dhd_pkg::entry_t                  wr_data;
	logic                             wr_en;
	logic [dhd_pkg::SLOT_W-1:0]       wr_addr;

	dhd_pkg::hash_res_t               hres;
	logic                             in_xfer;
	logic [dhd_pkg::SLOT_W:0]         pos_sum;
	logic [dhd_pkg::SLOT_W-1:0]       pos_next;
	logic [dhd_pkg::PROBE_W-1:0]      probe_next;
	logic                             hit;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot_index = dhd_pkg::SLOT_O_W'(out_slot_q);

	// Key hash unit
	dhd_hash u_hash (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_xfer),
		.key_length  (key_length),
		.key_symbols (key_symbols),
		.res         (hres)
	);

	// Advance the probe position by the step, modulo the table size
	assign pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_next   = (pos_sum >= {1'b0, dhd_pkg::MOD_POS}) ?
		dhd_pkg::SLOT_W'(pos_sum - {1'b0, dhd_pkg::MOD_POS}) : pos_sum[dhd_pkg::SLOT_W-1:0];
	assign probe_next = probe_count_q + 1'b1;
	assign hit        = rd_q.valid && (rd_q.key == key_q);

	// Table write port: clearing pass or insert into an empty slot
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '{valid: 1'b1, key: key_q};
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '{valid: 1'b0, key: '0};
		end else if (state_q == S_CHECK && !rd_q.valid && op_q == dhd_pkg::OP_INSERT) begin
			wr_en = 1'b1;
		end
	end

	// Table memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[pos_q];
	end

	// Sequence clear, hash, probe and result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			probe_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// Drop the result once transferred; the finish step reloads it
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == dhd_pkg::MOD_POS - 1'b1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						op_q    <= opcode;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hres.done) begin
						key_q         <= hres.key;
						pos_q         <= hres.pos;
						step_q        <= hres.step;
						probe_count_q <= '0;
						state_q       <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					probe_count_q <= probe_next;
					if (hit) begin
						stat_q  <= dhd_pkg::ST_FOUND;
						slot_q  <= pos_q;
						state_q <= S_FINISH;
					end else if (!rd_q.valid) begin
						if (op_q == dhd_pkg::OP_INSERT) begin
							stat_q <= dhd_pkg::ST_INSERTED;
							slot_q <= pos_q;
						end else begin
							stat_q <= dhd_pkg::ST_NOT_FOUND;
							slot_q <= '0;
						end
						state_q <= S_FINISH;
					end else if (probe_next == dhd_pkg::PROBE_W'(dhd_pkg::TABLE_SIZE)) begin
						stat_q  <= dhd_pkg::ST_FULL;
						slot_q  <= '0;
						state_q <= S_FINISH;
					end else begin
						pos_q   <= pos_next;
						state_q <= S_READ;
					end
				end
				S_FINISH: begin
					// Hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= stat_q;
						out_slot_q   <= slot_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An insert only writes a slot that was read empty
	a_write_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != S_CLEAR) |-> (!rd_q.valid && state_q == S_CHECK))
		else $error("table write over an occupied slot");

	// A miss or a full table reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == dhd_pkg::ST_NOT_FOUND || status == dhd_pkg::ST_FULL))
		|-> (slot_index == '0))
		else $error("nonzero slot on miss or full");

	// Hash completion only while the sequencer waits for it
	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hres.done |-> (state_q == S_HASH))
		else $error("hash done outside hash step");

	// Probe position stays inside the table
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (pos_q < dhd_pkg::MOD_POS))
		else $error("probe position out of range");

endmodule

`default_nettype wire

// ===== sv/dhd_hash.sv =====
// ----------------------------------------------------------------------------
// dhd_hash - iterative key hash unit
// Folds the key symbols in Horner order, highest symbol first, one symbol a
// cycle, keeping the key value and its residues mod TABLE_SIZE and
// TABLE_SIZE-1. Reports the home slot and the probe step when done.
// ----------------------------------------------------------------------------
`default_nettype none

module dhd_hash (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [dhd_pkg::LEN_W-1:0]   key_length,
	input  wire logic [dhd_pkg::SYMS_W-1:0]  key_symbols,
	output dhd_pkg::hash_res_t               res
);

	typedef enum logic {
		H_IDLE,
		H_RUN
	} hstate_t;

	hstate_t                          state_q;
	logic [dhd_pkg::CNT_W-1:0]        cnt_q;
	logic [dhd_pkg::SYM_REG_W-1:0]    sym_q;
	logic [dhd_pkg::KEY_W-1:0]        key_q;
	logic [dhd_pkg::SLOT_W-1:0]       rpos_q;
	logic [dhd_pkg::SLOT_W-1:0]       rstep_q;

	logic [dhd_pkg::CNT_W-1:0]        len_sat;
	logic [dhd_pkg::SYM_IDX_W-1:0]    idx;
	logic [2:0]                       code;
	logic [dhd_pkg::KEY_W+2:0]        key_next;

	// Saturate the length to the symbol capacity
	assign len_sat = (key_length > dhd_pkg::LEN_W'(dhd_pkg::MAX_SYMBOLS)) ?
		dhd_pkg::CNT_W'(dhd_pkg::MAX_SYMBOLS) : dhd_pkg::CNT_W'(key_length);

	// Pick the current symbol and form its weight digit
	assign idx      = dhd_pkg::SYM_IDX_W'(cnt_q - 1'b1);
	assign code     = {1'b0, sym_q[{idx, 1'b0} +: 2]} + 3'd1;
	assign key_next = {3'b000, key_q} + {1'b0, key_q, 2'b00} + (dhd_pkg::KEY_W+3)'(code);

	// Sequence the fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						cnt_q   <= len_sat;
						sym_q   <= dhd_pkg::SYM_REG_W'(key_symbols);
						key_q   <= '0;
						rpos_q  <= '0;
						rstep_q <= '0;
						state_q <= H_RUN;
					end
				end
				H_RUN: begin
					if (cnt_q == '0) begin
						state_q <= H_IDLE;
					end else begin
						key_q   <= key_next[dhd_pkg::KEY_W-1:0];
						rpos_q  <= dhd_pkg::red5(rpos_q, code, dhd_pkg::MOD_POS);
						rstep_q <= dhd_pkg::red5(rstep_q, code, dhd_pkg::MOD_STEP);
						cnt_q   <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

	// Step is (1 + key) mod (TABLE_SIZE - 1)
	always_comb begin
		res.done = (state_q == H_RUN) && (cnt_q == '0);
		res.key  = key_q;
		res.pos  = rpos_q;
		if (rstep_q == dhd_pkg::MOD_STEP - 1'b1) begin
			res.step = '0;
		end else begin
			res.step = rstep_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
